[sv/sacl_pkg.sv]
`timescale 1ns / 1ps
package sacl_pkg;
  localparam int unsigned TagW   = 32;
  localparam int unsigned UseW   = 32;
  localparam int unsigned StampW = 48;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] RegSetBits   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffBits   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWays      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPolicy    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHitTime   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMissPen   = 3'd5;

  localparam logic PolicyLru = 1'b0;
  localparam logic PolicyLfu = 1'b1;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkUpdate
  } bk_state_e;

  typedef struct packed {
    logic [3:0] set_bits;
    logic [4:0] offset_bits;
    logic [3:0] ways_in_use;
    logic       replace_policy;
    logic [7:0] hit_time;
    logic [9:0] miss_penalty;
  } cfg_t;
endpackage

[sv/sacl_front.sv]
`timescale 1ns / 1ps
// Splits each address into set index and tag and holds them in a small queue.
module sacl_front import sacl_pkg::*; #(
  parameter int unsigned SetW  = 8,
  parameter int unsigned AddrW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic [31:0]     req_addr_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output logic [SetW-1:0] q_set_o,
  output logic [TagW-1:0] q_tag_o
);
  localparam int unsigned EntW = SetW + TagW;

  logic [EntW-1:0] ent_q [2];
  logic [EntW-1:0] ent_d;
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push, pop;
  logic [AddrW-1:0] addr;
  logic [5:0]  shift;
  logic [AddrW-1:0] sh_off, sh_tag;
  logic [AddrW-1:0] set_mask;
  logic [TagW-1:0] tag;
  logic [SetW-1:0] set;

  always_comb begin
    addr     = req_addr_i[AddrW-1:0];
    shift    = {2'b00, cfg_i.set_bits} + {1'b0, cfg_i.offset_bits};
    sh_off   = addr >> cfg_i.offset_bits;
    set_mask = ~({AddrW{1'b1}} << cfg_i.set_bits);
    set      = SetW'(sh_off & set_mask);
    sh_tag   = addr >> shift;
    tag      = (32'(shift) >= 32'(AddrW)) ? '0 : TagW'(sh_tag);
    ent_d    = {set, tag};
  end

  assign req_ready_o = (cnt_q != 2'd2);
  assign q_valid_o   = (cnt_q != 2'd0);
  assign push = req_valid_i && req_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign {q_set_o, q_tag_o} = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    rd_d  = rd_q ^ pop;
    wr_d  = wr_q ^ push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= ent_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
`endif
endmodule

[sv/sacl_back.sv]
`timescale 1ns / 1ps
// Reads a set, resolves hit or victim, writes the line back, keeps counters.
// After reset the valid bits are cleared one set per cycle, over all Sets rows.
module sacl_back import sacl_pkg::*; #(
  parameter int unsigned SetW = 8,
  parameter int unsigned Ways = 8,
  parameter int unsigned Sets = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  logic [SetW-1:0]   q_set_i,
  input  logic [TagW-1:0]   q_tag_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              res_hit_o,
  output logic [2:0]        res_way_o,
  output logic [StampW-1:0] res_cycles_o,
  output logic [CntW-1:0]   res_miss_o,
  output logic [CntW-1:0]   res_access_o
);
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned RowW = (Sets > 1) ? $clog2(Sets) : 1;
  localparam logic [StampW-1:0] Max48 = {StampW{1'b1}};
  localparam logic [CntW-1:0]   Max32 = {CntW{1'b1}};

  logic [TagW-1:0]   tag_mem   [Sets][Ways];
  logic [UseW-1:0]   use_mem   [Sets][Ways];
  logic [StampW-1:0] stamp_mem [Sets][Ways];
  logic [Ways-1:0]   valid_mem [Sets];

  logic [TagW-1:0]   rd_tag   [Ways];
  logic [UseW-1:0]   rd_use   [Ways];
  logic [StampW-1:0] rd_stamp [Ways];
  logic [Ways-1:0]   rd_valid;

  bk_state_e state_q, state_d;
  logic [RowW-1:0] row_q;
  logic [TagW-1:0] tag_q;
  logic [StampW-1:0] cyc_q, cyc_d;
  logic [CntW-1:0] miss_q, miss_d, acc_q, acc_d;
  logic out_v_q, out_hit_q;
  logic [2:0] out_way_q;
  logic clr_q;
  logic [RowW-1:0] clr_row_q;

  logic [4:0] ways_eff;
  logic hit;
  logic [WayW-1:0] hit_way, free_way, vic_way, sel_way;
  logic free_found;
  logic [StampW:0] sum;
  logic [10:0] charge;
  logic [UseW-1:0] new_use;
  logic take, upd;

  always_comb begin
    ways_eff = (cfg_i.ways_in_use == 4'd0) ? 5'd1 : {1'b0, cfg_i.ways_in_use};
    if (32'(ways_eff) > Ways) ways_eff = 5'(Ways);
  end

  // Way compare and victim search over the registered row.
  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    free_found = 1'b0;
    free_way = '0;
    vic_way = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (w < 32'(ways_eff)) begin
        if (rd_valid[w] && rd_tag[w] == tag_q) begin
          hit = 1'b1;
          hit_way = WayW'(w);
        end
        if (!rd_valid[w]) begin
          free_found = 1'b1;
          free_way = WayW'(w);
        end
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (w < 32'(ways_eff)) begin
        if (cfg_i.replace_policy == PolicyLfu) begin
          if (rd_use[w] < rd_use[vic_way]) vic_way = WayW'(w);
        end else begin
          if (rd_stamp[w] < rd_stamp[vic_way]) vic_way = WayW'(w);
        end
      end
    end
    sel_way = hit ? hit_way : (free_found ? free_way : vic_way);
    charge  = hit ? {3'b000, cfg_i.hit_time}
                  : ({3'b000, cfg_i.hit_time} + {1'b0, cfg_i.miss_penalty});
    sum     = {1'b0, cyc_q} + {{(StampW-10){1'b0}}, charge};
    cyc_d   = sum[StampW] ? Max48 : sum[StampW-1:0];
    new_use = hit ? ((rd_use[sel_way] == Max32) ? Max32 : rd_use[sel_way] + 1'b1)
                  : UseW'(1);
    miss_d  = (!hit && miss_q != Max32) ? miss_q + 1'b1 : miss_q;
    acc_d   = (acc_q != Max32) ? acc_q + 1'b1 : acc_q;
  end

  assign q_ready_o = !clr_q && (state_q == BkIdle) && (!out_v_q || res_ready_i);
  assign take = q_valid_i && q_ready_o;
  assign upd  = (state_q == BkUpdate);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:   if (take) state_d = BkRead;
      BkRead:   state_d = BkUpdate;
      BkUpdate: state_d = BkIdle;
      default:  state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      cyc_q     <= '0;
      miss_q    <= '0;
      acc_q     <= '0;
      out_v_q   <= 1'b0;
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == RowW'(Sets - 1)) clr_q <= 1'b0;
      end
      if (upd) begin
        cyc_q   <= cyc_d;
        miss_q  <= miss_d;
        acc_q   <= acc_d;
        out_v_q <= 1'b1;
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q <= RowW'(q_set_i);
      tag_q <= q_tag_i;
    end
    if (state_q == BkRead) begin
      for (int w = 0; w < Ways; w++) begin
        rd_tag[w]   <= tag_mem[row_q][w];
        rd_use[w]   <= use_mem[row_q][w];
        rd_stamp[w] <= stamp_mem[row_q][w];
      end
      rd_valid <= valid_mem[row_q];
    end
    if (clr_q) begin
      valid_mem[clr_row_q] <= '0;
    end else if (upd) begin
      valid_mem[row_q][sel_way] <= 1'b1;
    end
    if (upd) begin
      tag_mem[row_q][sel_way]   <= tag_q;
      use_mem[row_q][sel_way]   <= new_use;
      stamp_mem[row_q][sel_way] <= cyc_d;
      out_hit_q <= hit;
      out_way_q <= 3'(sel_way);
    end
  end

  assign res_valid_o  = out_v_q;
  assign res_hit_o    = out_hit_q;
  assign res_way_o    = out_way_q;
  assign res_cycles_o = cyc_q;
  assign res_miss_o   = miss_q;
  assign res_access_o = acc_q;

`ifndef SYNTHESIS
  a_upd_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkRead |=> state_q == BkUpdate) else $error("read not followed by update");
  a_result_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> out_v_q) else $error("result lost");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> state_q == BkIdle) else $error("accept while busy");
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !clr_q) else $error("accept during clearing pass");
`endif
endmodule

[sv/set_assoc_cache_lru_lfu_model.sv]
`timescale 1ns / 1ps
// Tag-only set-associative cache model with LRU or LFU replacement.
// Requests arrive on the s_axis channel: tdata holds one 32-bit byte address.
// Results leave on m_axis: tdata packs hit, way, total_cycles, miss_total and
// access_total, one result for every request, in order.
// A front stage splits each address into set and tag and parks it in a
// two-entry queue; the back stage reads the set's lines (BkRead), then
// resolves hit or victim and writes the line and counters back (BkUpdate),
// and only then returns to idle to take its next request. The single
// read-then-write of the line storage thus holds one request at a time.
// When the receiver stalls the result is held in the output register; the
// queue still takes up to two more requests before s_axis_tready drops.
// Reset clears the counters and sets the configuration to its defaults; the
// valid bits are then cleared one set per cycle over all MAX_SETS sets; the
// back stage takes no request until that pass is done. The user is to write
// configuration via cfg_we_i/cfg_idx_i/cfg_data_i while idle; not enforced.
module set_assoc_cache_lru_lfu_model import sacl_pkg::*; #(
  parameter int unsigned MAX_SETS  = 256,
  parameter int unsigned MAX_WAYS  = 8,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // address[31:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // hit[0], way[3:1], total_cycles[51:4], miss_total[83:52],
  // access_total[115:84], zero fill [119:116]
  output logic [119:0]        m_axis_tdata
);
  localparam int unsigned SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{set_bits: 4'd0, offset_bits: 5'd0, ways_in_use: 4'd8,
                 replace_policy: PolicyLru, hit_time: 8'd1, miss_penalty: 10'd100};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSetBits: cfg_q.set_bits       <= cfg_data_i[3:0];
        RegOffBits: cfg_q.offset_bits    <= cfg_data_i[4:0];
        RegWays:    cfg_q.ways_in_use    <= cfg_data_i[3:0];
        RegPolicy:  cfg_q.replace_policy <= cfg_data_i[0];
        RegHitTime: cfg_q.hit_time       <= cfg_data_i[7:0];
        RegMissPen: cfg_q.miss_penalty   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic            q_valid, q_ready;
  logic [SetW-1:0] q_set;
  logic [TagW-1:0] q_tag;
  logic            r_hit;
  logic [2:0]      r_way;
  logic [StampW-1:0] r_cyc;
  logic [CntW-1:0] r_miss, r_acc;

  sacl_front #(.SetW(SetW), .AddrW(ADDR_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .req_valid_i(s_axis_tvalid), .req_ready_o(s_axis_tready),
    .req_addr_i(s_axis_tdata),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_set_o(q_set), .q_tag_o(q_tag)
  );

  sacl_back #(.SetW(SetW), .Ways(MAX_WAYS), .Sets(MAX_SETS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_set_i(q_set), .q_tag_i(q_tag),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_hit_o(r_hit), .res_way_o(r_way), .res_cycles_o(r_cyc),
    .res_miss_o(r_miss), .res_access_o(r_acc)
  );

  assign m_axis_tdata = {4'b0000, r_acc, r_miss, r_cyc, r_way, r_hit};
endmodule

[test/tb_set_assoc_cache_lru_lfu_model.sv]
`timescale 1ns / 1ps
// The address requests are driven from a queue, and results are checked
// against a behavioral model of the cache that runs inside the testbench.
module tb_set_assoc_cache_lru_lfu_model;
  import sacl_pkg::*;

  localparam int NSets = 256;
  localparam int NWays = 8;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegSetBits;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;

  always #10 clk_i = ~clk_i;

  set_assoc_cache_lru_lfu_model dut (.*);

  // Each result is packed as the block packs it on m_axis_tdata.
  typedef struct packed {
    logic [31:0] access_total;
    logic [31:0] miss_total;
    logic [47:0] total_cycles;
    logic [2:0]  way;
    logic        hit;
  } cache_res_t;

  // The testbench's own copy of the cache state and configuration.
  cfg_t        cfg_m;
  bit          lv[NSets*NWays];
  logic [31:0] ltag[NSets*NWays];
  logic [31:0] luse[NSets*NWays];
  logic [47:0] lstamp[NSets*NWays];
  logic [47:0] cyc_m;
  logic [31:0] miss_m, acc_m;

  logic [31:0] addr_q[$];
  cache_res_t  res_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // Predicts one access and updates the model state.
  function automatic cache_res_t lookup_line(logic [31:0] addr);
    cache_res_t r;
    int sh, setx, nw, base, w, vic;
    logic [31:0] tg;
    bit hit, found;
    sh = cfg_m.set_bits + cfg_m.offset_bits;
    tg = (sh >= 32) ? 32'd0 : addr >> sh;
    setx = ((64'(addr) >> cfg_m.offset_bits) & ((64'd1 << cfg_m.set_bits) - 1)) % NSets;
    nw = cfg_m.ways_in_use;
    if (nw < 1) nw = 1;
    if (nw > NWays) nw = NWays;
    base = setx * NWays;
    if (acc_m != '1) acc_m++;
    hit = 0;
    vic = 0;
    for (w = 0; w < nw; w++)
      if (!hit && lv[base+w] && ltag[base+w] == tg) begin
        hit = 1;
        vic = w;
      end
    if (hit) begin
      if (luse[base+vic] != '1) luse[base+vic]++;
      cyc_m = sat48(cyc_m, 48'(cfg_m.hit_time));
      lstamp[base+vic] = cyc_m;
    end else begin
      found = 0;
      for (w = 0; w < nw; w++)
        if (!found && !lv[base+w]) begin
          vic = w;
          found = 1;
        end
      if (!found) begin
        vic = 0;
        for (w = 1; w < nw; w++)
          if (cfg_m.replace_policy == PolicyLfu) begin
            if (luse[base+w] < luse[base+vic]) vic = w;
          end else begin
            if (lstamp[base+w] < lstamp[base+vic]) vic = w;
          end
      end
      cyc_m = sat48(cyc_m, 48'(cfg_m.hit_time) + 48'(cfg_m.miss_penalty));
      lv[base+vic] = 1;
      ltag[base+vic] = tg;
      luse[base+vic] = 1;
      lstamp[base+vic] = cyc_m;
      if (miss_m != '1) miss_m++;
    end
    r.hit = hit;
    r.way = 3'(vic);
    r.total_cycles = cyc_m;
    r.miss_total = miss_m;
    r.access_total = acc_m;
    return r;
  endfunction

  // Driver: bursts of requests separated by random gaps. A request that is
  // shown stays unchanged until it is taken.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) begin
        void'(addr_q.pop_front());
        if (burst_left <= 0) begin
          burst_left = $urandom_range(30, 1);
          gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else burst_left = burst_left - 1;
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (addr_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= addr_q[0];
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // Monitor and receiver stall pattern; the watchdog counts idle cycles.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    cache_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[115:0];
        if (m_axis_tdata[119:116] != 0) begin
          $error("fill bits: expected 0 actual %0h", m_axis_tdata[119:116]);
          errors++;
        end
        if (res_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          want = res_q.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, got.hit); errors++;
          end
          if (got.way !== want.way) begin
            $error("way: expected %0d actual %0d", want.way, got.way); errors++;
          end
          if (got.total_cycles !== want.total_cycles) begin
            $error("total_cycles: expected %0d actual %0d", want.total_cycles,
                   got.total_cycles); errors++;
          end
          if (got.miss_total !== want.miss_total) begin
            $error("miss_total: expected %0d actual %0d", want.miss_total,
                   got.miss_total); errors++;
          end
          if (got.access_total !== want.access_total) begin
            $error("access_total: expected %0d actual %0d", want.access_total,
                   got.access_total); errors++;
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          res_q.size() == 0)
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(3, 0);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(3, 0) != 0);
        2: m_axis_tready <= ($urandom_range(1, 0) != 0);
        default: m_axis_tready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  always @(posedge clk_i)
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegSetBits: cfg_m.set_bits = val[3:0];
      RegOffBits: cfg_m.offset_bits = val[4:0];
      RegWays:    cfg_m.ways_in_use = val[3:0];
      RegPolicy:  cfg_m.replace_policy = val[0];
      RegHitTime: cfg_m.hit_time = val[7:0];
      RegMissPen: cfg_m.miss_penalty = val[9:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_addr(logic [31:0] a);
    res_q.push_back(lookup_line(a));
    addr_q.push_back(a);
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic drain_block();
    while (addr_q.size() != 0 || res_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Addresses drawn from a small pool of tags so sets fill and lines hit.
  function automatic logic [31:0] pick_addr(int span);
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(9, 0))
      0: return a;
      1: return 32'hFFFF_FFFF ^ (a & 32'h0000_00FF);
      default: begin
        a = ($urandom_range(span - 1, 0) << (cfg_m.set_bits + cfg_m.offset_bits))
            | (($urandom_range(3, 0)) << cfg_m.offset_bits) | ($urandom() & 32'h3);
        return a;
      end
    endcase
  endfunction

  initial begin
    cfg_m = '{set_bits: 0, offset_bits: 0, ways_in_use: 8, replace_policy: PolicyLru,
              hit_time: 1, miss_penalty: 100};
    foreach (lv[i]) lv[i] = 0;
    cyc_m = '0; miss_m = '0; acc_m = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults with a single set, extremes of the address.
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    for (int i = 1; i <= 8; i++) send_addr(32'h100 * i);
    send_addr(32'h100);
    send_addr(32'h1234_5678);
    drain_block();
    // LFU with full set, zero ways acting as one, extreme timing.
    write_reg(RegPolicy, CfgDataW'(PolicyLfu));
    write_reg(RegWays, 10'd0);
    write_reg(RegHitTime, 10'd255);
    write_reg(RegMissPen, 10'd1023);
    send_addr(32'h5); send_addr(32'h5); send_addr(32'h6);
    drain_block();
    // Ways above eight, and a shift that swallows the whole address.
    write_reg(RegWays, 10'd15);
    write_reg(RegSetBits, 10'd15);
    write_reg(RegOffBits, 10'd31);
    send_addr(32'hAAAA_5555); send_addr(32'h5555_AAAA);
    drain_block();
    write_reg(RegSetBits, 10'd8);
    write_reg(RegOffBits, 10'd16);
    send_addr(32'hFFFF_0000); send_addr(32'h00FF_FFFF); send_addr(32'hFFFF_FFFF);
    drain_block();

    // Random phases across several settings.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(RegSetBits, CfgDataW'($urandom_range(8, 0)));
      write_reg(RegOffBits, CfgDataW'((ph == 3) ? 16 : $urandom_range(6, 0)));
      write_reg(RegWays, CfgDataW'((ph == 5) ? 1 : $urandom_range(8, 1)));
      write_reg(RegPolicy, CfgDataW'(ph[0]));
      write_reg(RegHitTime, CfgDataW'((ph == 7) ? 0 : $urandom_range(255, 0)));
      write_reg(RegMissPen, CfgDataW'((ph == 7) ? 0 : $urandom_range(1023, 0)));
      for (int k = 0; k < 95; k++) send_addr(pick_addr($urandom_range(12, 2)));
      drain_block();
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[filelist.f]
sv/sacl_pkg.sv
sv/sacl_front.sv
sv/sacl_back.sv
sv/set_assoc_cache_lru_lfu_model.sv
test/tb_set_assoc_cache_lru_lfu_model.sv
